// ===== src/cfp_pkg.sv =====
// ----------------------------------------------------------------------------
// cfp_pkg
// Shared types, constants and the CRC-8 byte update for the frame parser.
// ----------------------------------------------------------------------------
package cfp_pkg;

  // Field widths
  localparam int BYTE_W = 8;
  localparam int LEN_W  = 6;
  localparam int IDLE_W = 16;
  localparam int KIND_W = 2;

  // APB register port
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  // Register indexes (word address bits)
  localparam logic [1:0] REG_SYNC    = 2'd0;
  localparam logic [1:0] REG_LIMIT   = 2'd1;
  localparam logic [1:0] REG_TIMEOUT = 2'd2;

  // Register reset values
  localparam logic [BYTE_W-1:0] SYNC_RST    = 8'hAA;
  localparam logic [LEN_W-1:0]  LIMIT_RST   = 6'd32;
  localparam logic [IDLE_W-1:0] TIMEOUT_RST = 16'd500;

  // Line noise dropped while hunting
  localparam logic [BYTE_W-1:0] NOISE_LO = 8'h00;
  localparam logic [BYTE_W-1:0] NOISE_HI = 8'hFF;

  // CRC-8, MSB first
  localparam logic [BYTE_W-1:0] CRC_POLY = 8'h07;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_HEADER  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CRC_ERR = 2'd2;

  // Configuration registers as seen by the datapath
  typedef struct packed {
    logic [BYTE_W-1:0] sync_value;
    logic [LEN_W-1:0]  length_limit;
    logic [IDLE_W-1:0] gap_timeout;
  } cfp_cfg_t;

  // Parser / drain sequencer
  typedef enum logic [6:0] {
    ST_HUNT = 7'b0000001,
    ST_LEN  = 7'b0000010,
    ST_CMD  = 7'b0000100,
    ST_PAY  = 7'b0001000,
    ST_CRC  = 7'b0010000,
    ST_RD   = 7'b0100000,
    ST_DATA = 7'b1000000
  } state_t;

  // One byte through the CRC-8 shift register
  function automatic logic [BYTE_W-1:0] crc8_update(input logic [BYTE_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] data);
    logic [BYTE_W-1:0] c;
    c = crc ^ data;
    for (int i = 0; i < BYTE_W; i++) begin
      c = c[BYTE_W-1] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

// ===== src/cfp_in_if.sv =====
// ----------------------------------------------------------------------------
// cfp_in_if
// Input channel: received bytes and millisecond ticks.
// ----------------------------------------------------------------------------
interface cfp_in_if;
  import cfp_pkg::*;

  logic              valid;
  logic              ready;
  logic              req_type;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, req_type, rx_byte, input ready);
  modport sink   (input valid, req_type, rx_byte, output ready);
endinterface

// ===== src/cfp_out_if.sv =====
// ----------------------------------------------------------------------------
// cfp_out_if
// Result channel: frame header, payload bytes and CRC errors.
// ----------------------------------------------------------------------------
interface cfp_out_if;
  import cfp_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] item_kind;
  logic [BYTE_W-1:0] value;
  logic [LEN_W-1:0]  frame_length;
  logic              last;

  modport source (output valid, item_kind, value, frame_length, last, input ready);
  modport sink   (input valid, item_kind, value, frame_length, last, output ready);
endinterface

// ===== src/cfp_regs.sv =====
// ----------------------------------------------------------------------------
// cfp_regs
// APB register file: sync byte, payload length limit and gap timeout.
// ----------------------------------------------------------------------------
module cfp_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cfp_pkg::ADDR_W-1:0]  paddr,
  input  logic [cfp_pkg::DATA_W-1:0]  pwdata,
  output logic [cfp_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output cfp_pkg::cfp_cfg_t           cfg
);
  import cfp_pkg::*;

  cfp_cfg_t   cfg_r, cfg_nxt;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[3:2];
  assign cfg     = cfg_r;

  // Write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        REG_SYNC:    cfg_nxt.sync_value   = pwdata[BYTE_W-1:0];
        REG_LIMIT:   cfg_nxt.length_limit = pwdata[LEN_W-1:0];
        REG_TIMEOUT: cfg_nxt.gap_timeout  = pwdata[IDLE_W-1:0];
        default:     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sync_value   <= SYNC_RST;
      cfg_r.length_limit <= LIMIT_RST;
      cfg_r.gap_timeout  <= TIMEOUT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Read mux
  always_comb begin
    unique case (reg_idx)
      REG_SYNC:    prdata = DATA_W'(cfg_r.sync_value);
      REG_LIMIT:   prdata = DATA_W'(cfg_r.length_limit);
      REG_TIMEOUT: prdata = DATA_W'(cfg_r.gap_timeout);
      default:     prdata = '0;
    endcase
  end

endmodule

// ===== src/crc8_frame_parser.sv =====
// ----------------------------------------------------------------------------
// crc8_frame_parser
// Deframes sync / length / command / payload / CRC-8 frames from a byte
// stream with millisecond ticks; a good frame comes out as a header word
// and its payload words from the payload store, a bad CRC as an error word.
// ----------------------------------------------------------------------------
//  channel   direction  handshake          word
//  in_ch     in         valid/ready        req_type, rx_byte
//  out_ch    out        valid/ready        item_kind, value, frame_length, last
//  APB       in/out     psel/penable       sync_value, length_limit, gap_timeout
//
//  A byte or tick is accepted whenever in_ch.valid is high while parsing.
//  A good CRC loads the header; each payload word is then read from the
//  store in ST_RD and loaded into the output register in ST_DATA, which
//  waits for a free output register; input is held off during the drain.
//  The CRC byte waits until the output register is empty.
//  Reset is synchronous and clears control state; the payload store is not
//  cleared.
// ----------------------------------------------------------------------------
module crc8_frame_parser #(
  parameter int MAX_PAYLOAD = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  cfp_in_if.sink                      in_ch,
  cfp_out_if.source                   out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cfp_pkg::ADDR_W-1:0]  paddr,
  input  logic [cfp_pkg::DATA_W-1:0]  pwdata,
  output logic [cfp_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import cfp_pkg::*;

  localparam int         AW   = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam logic [8:0] MAXP = 9'(MAX_PAYLOAD);

  cfp_cfg_t cfg;

  cfp_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Parser state
  state_t            state_r, state_nxt;
  logic [LEN_W-1:0]  cnt_r, cnt_nxt;
  logic [LEN_W-1:0]  exp_len_r, exp_len_nxt;
  logic [BYTE_W-1:0] cmd_r, cmd_nxt;
  logic [BYTE_W-1:0] crc_r, crc_nxt;
  logic [IDLE_W-1:0] idle_r, idle_nxt;
  logic [LEN_W-1:0]  drain_idx_r, drain_idx_nxt;

  // Payload store and its registered read port
  logic [BYTE_W-1:0] payload_mem_r [MAX_PAYLOAD];
  logic [BYTE_W-1:0] rd_data_r;
  logic              mem_we;

  // Output register
  logic              out_valid_r, out_valid_nxt;
  logic [KIND_W-1:0] out_kind_r, out_kind_nxt;
  logic [BYTE_W-1:0] out_value_r, out_value_nxt;
  logic [LEN_W-1:0]  out_len_r, out_len_nxt;
  logic              out_last_r, out_last_nxt;

  logic              in_ready, in_fire, out_free, noise, drain_last;
  logic [BYTE_W-1:0] rx;
  logic [8:0]        limit9;
  logic [IDLE_W-1:0] idle_inc;
  logic [LEN_W-1:0]  cnt_inc;

  assign rx       = in_ch.rx_byte;
  assign noise    = (rx == NOISE_LO) || (rx == NOISE_HI);
  assign in_ready = (state_r == ST_HUNT) || (state_r == ST_LEN) || (state_r == ST_CMD) ||
                    (state_r == ST_PAY)  || ((state_r == ST_CRC) && !out_valid_r);
  assign in_fire  = in_ch.valid && in_ready;
  assign out_free = !out_valid_r || out_ch.ready;

  assign limit9     = ({3'b0, cfg.length_limit} < MAXP) ? {3'b0, cfg.length_limit} : MAXP;
  assign idle_inc   = (idle_r == '1) ? idle_r : idle_r + 1'b1;
  assign cnt_inc    = cnt_r + 1'b1;
  assign drain_last = (drain_idx_r + 1'b1) == exp_len_r;

  assign in_ch.ready         = in_ready;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.item_kind    = out_kind_r;
  assign out_ch.value        = out_value_r;
  assign out_ch.frame_length = out_len_r;
  assign out_ch.last         = out_last_r;

  // Next state: byte/tick parsing and frame drain
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    exp_len_nxt   = exp_len_r;
    cmd_nxt       = cmd_r;
    crc_nxt       = crc_r;
    idle_nxt      = idle_r;
    drain_idx_nxt = drain_idx_r;
    mem_we        = 1'b0;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_kind_nxt  = out_kind_r;
    out_value_nxt = out_value_r;
    out_len_nxt   = out_len_r;
    out_last_nxt  = out_last_r;

    if (in_fire) begin
      if (in_ch.req_type) begin
        // tick: gap timer, resync mid-frame
        idle_nxt = idle_inc;
        if ((state_r != ST_HUNT) && (idle_inc > cfg.gap_timeout)) begin
          state_nxt = ST_HUNT;
          idle_nxt  = '0;
        end
      end else if (!((state_r == ST_HUNT) && noise)) begin
        idle_nxt = '0;
        unique case (state_r)
          ST_LEN: begin
            if ({1'b0, rx} > limit9) begin
              state_nxt = ST_HUNT;
            end else begin
              exp_len_nxt = rx[LEN_W-1:0];
              state_nxt   = ST_CMD;
            end
          end
          ST_CMD: begin
            cmd_nxt   = rx;
            crc_nxt   = crc8_update('0, rx);
            cnt_nxt   = '0;
            state_nxt = (exp_len_r == '0) ? ST_CRC : ST_PAY;
          end
          ST_PAY: begin
            mem_we  = {3'b0, cnt_r} < MAXP;
            cnt_nxt = cnt_inc;
            crc_nxt = crc8_update(crc_r, rx);
            if (cnt_inc >= exp_len_r) begin
              state_nxt = ST_CRC;
            end
          end
          ST_CRC: begin
            state_nxt     = ST_HUNT;
            out_valid_nxt = 1'b1;
            out_len_nxt   = exp_len_r;
            if (crc_r != rx) begin
              out_kind_nxt  = KIND_CRC_ERR;
              out_value_nxt = '0;
              out_last_nxt  = 1'b1;
            end else begin
              out_kind_nxt  = KIND_HEADER;
              out_value_nxt = cmd_r;
              out_last_nxt  = (exp_len_r == '0);
              if (exp_len_r != '0) begin
                state_nxt     = ST_RD;
                drain_idx_nxt = '0;
              end
            end
          end
          default: begin
            state_nxt = ST_HUNT;
            if (rx == cfg.sync_value) begin
              state_nxt   = ST_LEN;
              exp_len_nxt = '0;
              cnt_nxt     = '0;
            end
          end
        endcase
      end
    end

    // drain: read issued in ST_RD, word loaded in ST_DATA
    if (state_r == ST_RD) begin
      state_nxt = ST_DATA;
    end else if ((state_r == ST_DATA) && out_free) begin
      out_valid_nxt = 1'b1;
      out_kind_nxt  = KIND_PAYLOAD;
      out_value_nxt = rd_data_r;
      out_len_nxt   = exp_len_r;
      out_last_nxt  = drain_last;
      drain_idx_nxt = drain_idx_r + 1'b1;
      state_nxt     = drain_last ? ST_HUNT : ST_RD;
    end
  end

  // Control and parser registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_HUNT;
      cnt_r       <= '0;
      exp_len_r   <= '0;
      cmd_r       <= '0;
      crc_r       <= '0;
      idle_r      <= '0;
      drain_idx_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      exp_len_r   <= exp_len_nxt;
      cmd_r       <= cmd_nxt;
      crc_r       <= crc_nxt;
      idle_r      <= idle_nxt;
      drain_idx_r <= drain_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output word
  always_ff @(posedge clk) begin
    out_kind_r  <= out_kind_nxt;
    out_value_r <= out_value_nxt;
    out_len_r   <= out_len_nxt;
    out_last_r  <= out_last_nxt;
  end

  // Payload store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      payload_mem_r[AW'(cnt_r)] <= rx;
    end
    if (state_r == ST_RD) begin
      rd_data_r <= payload_mem_r[AW'(drain_idx_r)];
    end
  end

  // Checks
  a_crc_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !in_ch.req_type && (state_r == ST_CRC) |=> out_valid_r)
    else $error("CRC byte accepted without a result word");

  a_store_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> ({3'b0, cnt_r} < MAXP) && (cnt_r < exp_len_r))
    else $error("payload store written outside the frame");

  a_drain_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RD) || (state_r == ST_DATA) |-> drain_idx_r < exp_len_r)
    else $error("drain index beyond frame length");

  a_idle_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !in_ch.req_type && !((state_r == ST_HUNT) && noise) |=> idle_r == '0)
    else $error("gap timer not cleared by a received byte");

endmodule
